// ===== design/wud_pkg.sv =====
// ----------------------------------------------------------------------------
// wud_pkg
// Shared types and constants for the wide unsigned divider: request and
// response beats, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package wud_pkg;

  localparam int WORD_BITS  = 64;
  localparam int FULL_BITS  = 3 * WORD_BITS;
  localparam int SCALE_BITS = 5;

  typedef struct packed {
    logic [WORD_BITS-1:0]  dividend_lo;
    logic [WORD_BITS-1:0]  dividend_mid;
    logic [WORD_BITS-1:0]  dividend_hi;
    logic [WORD_BITS-1:0]  divisor_lo;
    logic [WORD_BITS-1:0]  divisor_mid;
    logic [WORD_BITS-1:0]  divisor_hi;
    logic                  dividend_sign;
    logic [SCALE_BITS-1:0] dividend_scale;
  } req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]  quotient_lo;
    logic [WORD_BITS-1:0]  quotient_mid;
    logic [WORD_BITS-1:0]  quotient_hi;
    logic [WORD_BITS-1:0]  remainder_lo;
    logic [WORD_BITS-1:0]  remainder_mid;
    logic [WORD_BITS-1:0]  remainder_hi;
    logic                  quotient_sign;
    logic [SCALE_BITS-1:0] quotient_scale;
    logic                  divide_by_zero;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load;     // capture operands
    logic step;     // one shift-and-subtract iteration
    logic publish;  // move the result into the response register
  } dp_cmd_t;

  typedef struct packed {
    logic zero_div; // captured divisor is zero
  } dp_status_t;

endpackage

// ===== design/wud_datapath.sv =====
// ----------------------------------------------------------------------------
// wud_datapath
// Operand, partial remainder and quotient registers with one restoring
// subtract stage; produces one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
module wud_datapath #(
  parameter int OPERAND_BITS = 192
) (
  input  logic                clk,
  input  wud_pkg::req_t       req_data,
  input  wud_pkg::dp_cmd_t    cmd,
  output wud_pkg::dp_status_t sts,
  output wud_pkg::rsp_t       rsp_data
);

  localparam int N = OPERAND_BITS;

  logic [wud_pkg::FULL_BITS-1:0]  dvd_full;
  logic [wud_pkg::FULL_BITS-1:0]  dvs_full;
  logic [N-1:0]                   dvd_in;
  logic [N-1:0]                   dvs_in;
  logic                           dvs_in_zero;

  logic [N-1:0]                   dvd;
  logic [N-1:0]                   dvs;
  logic [N-1:0]                   rem;
  logic [N-1:0]                   quo;
  logic                           zero_div;
  logic                           sign;
  logic [wud_pkg::SCALE_BITS-1:0] scale;

  logic [N:0]                     rem_sh;
  logic [N+1:0]                   diff;
  logic                           ge;
  logic                           quo_nonzero;
  logic [wud_pkg::FULL_BITS-1:0]  quo_full;
  logic [wud_pkg::FULL_BITS-1:0]  rem_full;

  assign dvd_full = {req_data.dividend_hi, req_data.dividend_mid, req_data.dividend_lo};
  assign dvs_full = {req_data.divisor_hi, req_data.divisor_mid, req_data.divisor_lo};
  assign dvd_in      = dvd_full[N-1:0];
  assign dvs_in      = dvs_full[N-1:0];
  assign dvs_in_zero = (dvs_in == '0);

  // Bring down the next dividend bit, then trial-subtract the divisor.
  assign rem_sh = {rem, dvd[N-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};
  assign ge     = ~diff[N+1];

  assign quo_nonzero = (quo != '0);
  assign quo_full    = wud_pkg::FULL_BITS'(quo);
  assign rem_full    = wud_pkg::FULL_BITS'(rem);

  assign sts.zero_div = zero_div;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd      <= dvd_in;
      dvs      <= dvs_in;
      quo      <= '0;
      zero_div <= dvs_in_zero;
      sign     <= req_data.dividend_sign;
      scale    <= req_data.dividend_scale;
      // A zero divisor skips the iterations: the remainder is the dividend.
      rem      <= dvs_in_zero ? dvd_in : '0;
    end else if (cmd.step) begin
      dvd <= {dvd[N-2:0], 1'b0};
      quo <= {quo[N-2:0], ge};
      rem <= ge ? diff[N-1:0] : rem_sh[N-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      rsp_data.quotient_lo    <= quo_full[wud_pkg::WORD_BITS-1:0];
      rsp_data.quotient_mid   <= quo_full[2*wud_pkg::WORD_BITS-1:wud_pkg::WORD_BITS];
      rsp_data.quotient_hi    <= quo_full[3*wud_pkg::WORD_BITS-1:2*wud_pkg::WORD_BITS];
      rsp_data.remainder_lo   <= rem_full[wud_pkg::WORD_BITS-1:0];
      rsp_data.remainder_mid  <= rem_full[2*wud_pkg::WORD_BITS-1:wud_pkg::WORD_BITS];
      rsp_data.remainder_hi   <= rem_full[3*wud_pkg::WORD_BITS-1:2*wud_pkg::WORD_BITS];
      rsp_data.quotient_sign  <= quo_nonzero ? sign : 1'b0;
      rsp_data.quotient_scale <= quo_nonzero ? scale : '0;
      rsp_data.divide_by_zero <= zero_div;
    end
  end

endmodule

// ===== design/wud_ctrl.sv =====
// ----------------------------------------------------------------------------
// wud_ctrl
// Sequencer for the divider: accepts a request beat, counts the iterations,
// and hands the result to the response register when it is free.
// ----------------------------------------------------------------------------
module wud_ctrl #(
  parameter int OPERAND_BITS = 192
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  wud_pkg::dp_status_t sts,
  output wud_pkg::dp_cmd_t    cmd
);

  localparam int CNT_W = $clog2(OPERAND_BITS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(OPERAND_BITS - 1);

  wud_pkg::state_t  state;
  wud_pkg::state_t  state_next;
  logic [CNT_W-1:0] count;
  logic             out_free;
  logic             run_done;

  assign out_free = ~rsp_valid | ~rsp_stall;
  assign run_done = sts.zero_div | (count == LAST);

  always_comb begin
    state_next = state;
    unique case (state)
      wud_pkg::ST_IDLE:  if (req_valid) state_next = wud_pkg::ST_RUN;
      wud_pkg::ST_RUN:   if (run_done)  state_next = wud_pkg::ST_DRAIN;
      wud_pkg::ST_DRAIN: if (out_free)  state_next = wud_pkg::ST_IDLE;
      default:           state_next = wud_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      wud_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      wud_pkg::ST_RUN: begin
        cmd.step = ~sts.zero_div;
      end
      wud_pkg::ST_DRAIN: begin
        cmd.publish = out_free;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wud_pkg::ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        count <= '0;
      end else if (cmd.step) begin
        count <= count + 1'b1;
      end
      // Hold the beat until taken; a new result may replace it in the same cycle.
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (~rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/wide_unsigned_divider.sv =====
// A request beat is captured, runs the shift-and-subtract loop (one quotient
// bit per step), then is handed off to the response register; a zero divisor
// skips the loop. The single shared subtract stage takes no new request until
// the last result is handed off, but a new request is taken while a response
// waits.
// Reset (rst, synchronous, active high) returns to idle with no response held.
// ----------------------------------------------------------------------------
// wide_unsigned_divider
// Restoring long division of wide unsigned operands; the quotient carries
// the dividend's sign and scale when it is nonzero, the remainder is unsigned.
// ----------------------------------------------------------------------------
module wide_unsigned_divider #(
  parameter int OPERAND_BITS = 192
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  wud_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output wud_pkg::rsp_t rsp_data
);

  wud_pkg::dp_cmd_t    cmd;
  wud_pkg::dp_status_t sts;

  wud_ctrl #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  wud_datapath #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_datapath (
    .clk      (clk),
    .req_data (req_data),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_data (rsp_data)
  );

endmodule

// ===== design/wud_checker.sv =====
// ----------------------------------------------------------------------------
// wud_checker
// Port-level checks for the wide unsigned divider, bound to the top level.
// ----------------------------------------------------------------------------
module wud_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input wud_pkg::rsp_t rsp_data
);

  logic quo_zero;

  assign quo_zero = (rsp_data.quotient_lo == '0) && (rsp_data.quotient_mid == '0) &&
                    (rsp_data.quotient_hi == '0);

  // Only one division in flight: a taken request beat closes the port.
  a_req_closes: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while a division is in flight");

  a_div_zero_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.divide_by_zero |->
      quo_zero && !rsp_data.quotient_sign && (rsp_data.quotient_scale == '0))
    else $error("divide by zero with nonzero quotient fields");

  a_zero_quo_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && quo_zero |-> !rsp_data.quotient_sign && (rsp_data.quotient_scale == '0))
    else $error("zero quotient carries sign or scale");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    $past(rsp_valid && rsp_stall) |-> rsp_valid && $stable(rsp_data))
    else $error("stalled response beat dropped or changed");

endmodule

bind wide_unsigned_divider wud_checker u_wud_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);

// ===== tb/division_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// division_checker
// Watches the request and response channels of the wide unsigned divider,
// works out the quotient, remainder, sign, scale and zero flag of every
// accepted request, and compares each response beat with the oldest one.
// ----------------------------------------------------------------------------
module division_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  wud_pkg::req_t req_data,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  wud_pkg::rsp_t rsp_data,
  output int            pending,
  output int            mismatches,
  output int            checked,
  output int            zero_divisors,
  output int            short_dividends
);

  localparam int WORD_BITS = wud_pkg::WORD_BITS;
  localparam int FULL_BITS = wud_pkg::FULL_BITS;

  wud_pkg::rsp_t quotient_q[$];

  initial begin
    pending         = 0;
    mismatches      = 0;
    checked         = 0;
    zero_divisors   = 0;
    short_dividends = 0;
  end

  function automatic wud_pkg::rsp_t divide_wide(input wud_pkg::req_t r);
    logic [FULL_BITS-1:0] num;
    logic [FULL_BITS-1:0] den;
    logic [FULL_BITS-1:0] quo;
    logic [FULL_BITS-1:0] rem;
    wud_pkg::rsp_t        res;
    num = {r.dividend_hi, r.dividend_mid, r.dividend_lo};
    den = {r.divisor_hi, r.divisor_mid, r.divisor_lo};
    res = '0;
    if (den == '0) begin
      // no loop: flag it, zero quotient, dividend handed back as remainder
      quo = '0;
      rem = num;
      res.divide_by_zero = 1'b1;
    end else begin
      quo = num / den;
      rem = num % den;
    end
    {res.quotient_hi, res.quotient_mid, res.quotient_lo}    = quo;
    {res.remainder_hi, res.remainder_mid, res.remainder_lo} = rem;
    if (quo != '0) begin
      res.quotient_sign  = r.dividend_sign;
      res.quotient_scale = r.dividend_scale;
    end
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [WORD_BITS-1:0] want,
                                      input logic [WORD_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    wud_pkg::rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (quotient_q.size() == 0) begin
          $error("response beat with no division outstanding");
          mismatches++;
        end else begin
          want = quotient_q.pop_front();
          check_field("quotient_lo", want.quotient_lo, rsp_data.quotient_lo);
          check_field("quotient_mid", want.quotient_mid, rsp_data.quotient_mid);
          check_field("quotient_hi", want.quotient_hi, rsp_data.quotient_hi);
          check_field("remainder_lo", want.remainder_lo, rsp_data.remainder_lo);
          check_field("remainder_mid", want.remainder_mid, rsp_data.remainder_mid);
          check_field("remainder_hi", want.remainder_hi, rsp_data.remainder_hi);
          check_field("quotient_sign", WORD_BITS'(want.quotient_sign),
                      WORD_BITS'(rsp_data.quotient_sign));
          check_field("quotient_scale", WORD_BITS'(want.quotient_scale),
                      WORD_BITS'(rsp_data.quotient_scale));
          check_field("divide_by_zero", WORD_BITS'(want.divide_by_zero),
                      WORD_BITS'(rsp_data.divide_by_zero));
          checked++;
        end
      end
      if (req_valid && !req_stall) begin
        want = divide_wide(req_data);
        quotient_q.push_back(want);
        if (want.divide_by_zero)
          zero_divisors++;
        else if ({want.quotient_hi, want.quotient_mid, want.quotient_lo} == '0)
          short_dividends++;
      end
    end
    pending <= quotient_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the wide unsigned divider with directed corner divisions and then
// random operands of every bit length, under four idling phases, a long
// response hold-off and full drains; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FULL_BITS    = wud_pkg::FULL_BITS;
  localparam int SCALE_BITS   = wud_pkg::SCALE_BITS;
  localparam int PHASE_ITEMS  = 460;
  localparam int HOLDOFF_LEN  = 600;
  localparam int SETTLE_TIME  = 250;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  wud_pkg::req_t req_data;
  logic          rsp_valid;
  logic          rsp_stall;
  wud_pkg::rsp_t rsp_data;

  int   pending;
  int   mismatches;
  int   checked;
  int   zero_divisors;
  int   short_dividends;

  int   idle_pct;
  int   stall_pct;
  logic holdoff_token;

  wide_unsigned_divider dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  division_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req_data        (req_data),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .rsp_data        (rsp_data),
    .pending         (pending),
    .mismatches      (mismatches),
    .checked         (checked),
    .zero_divisors   (zero_divisors),
    .short_dividends (short_dividends)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // Response side: random stall, or a counted hold-off when the token flips.
  initial begin : receiver
    logic seen;
    int   hold_left;
    rsp_stall = 1'b0;
    seen      = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (holdoff_token != seen) begin
        seen      = holdoff_token;
        hold_left = HOLDOFF_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic wud_pkg::req_t make_div(input logic [FULL_BITS-1:0] num,
                                             input logic [FULL_BITS-1:0] den,
                                             input logic sign,
                                             input logic [SCALE_BITS-1:0] scale);
    wud_pkg::req_t r;
    {r.dividend_hi, r.dividend_mid, r.dividend_lo} = num;
    {r.divisor_hi, r.divisor_mid, r.divisor_lo}    = den;
    r.dividend_sign  = sign;
    r.dividend_scale = scale;
    return r;
  endfunction

  // Random value of random bit length, so quotients of every size show up.
  function automatic logic [FULL_BITS-1:0] rand_wide();
    logic [FULL_BITS-1:0] v;
    int                   len;
    v   = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    len = $urandom_range(FULL_BITS, 0);
    if (len < FULL_BITS)
      v &= (FULL_BITS'(1) << len) - FULL_BITS'(1);
    return v;
  endfunction

  function automatic wud_pkg::req_t rand_div();
    logic [FULL_BITS-1:0]  num;
    logic [FULL_BITS-1:0]  den;
    logic [SCALE_BITS-1:0] scale;
    int                    pick;
    num  = rand_wide();
    den  = rand_wide();
    pick = $urandom_range(99);
    if (pick < 4)
      den = '0;
    else if (pick < 8)
      num = den;
    else if (pick < 12)
      num = den - FULL_BITS'(1);
    else if (pick < 15)
      num = '1;
    if ($urandom_range(9) == 0)
      scale = SCALE_BITS'($urandom_range(31, 29));
    else
      scale = SCALE_BITS'($urandom_range(28));
    return make_div(num, den, 1'(($urandom_range(1))), scale);
  endfunction

  task automatic send_div(input wud_pkg::req_t item);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    do @(posedge clk); while (req_stall);
  endtask

  // Drop valid and hold until every outstanding division has come back.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [FULL_BITS-1:0] ones;
    logic [FULL_BITS-1:0] top_bit;
    logic [FULL_BITS-1:0] r1;
    ones          = '1;
    top_bit       = FULL_BITS'(1) << (FULL_BITS - 1);
    rst           = 1'b1;
    req_valid     = 1'b0;
    req_data      = '0;
    holdoff_token = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_div(make_div('0, FULL_BITS'(1), 1'b0, '0));
    send_div(make_div(ones, FULL_BITS'(1), 1'b1, 5'd28));
    send_div(make_div(ones, ones, 1'b1, 5'd31));
    send_div(make_div(ones, '0, 1'b1, 5'd31));
    send_div(make_div('0, '0, 1'b0, 5'd3));
    send_div(make_div(FULL_BITS'(5), FULL_BITS'(7), 1'b1, 5'd5));
    send_div(make_div(FULL_BITS'(7), FULL_BITS'(7), 1'b1, 5'd31));
    send_div(make_div(FULL_BITS'(1), ones, 1'b1, 5'd28));
    send_div(make_div(ones, top_bit, 1'b0, 5'd17));
    send_div(make_div(top_bit, top_bit - FULL_BITS'(1), 1'b1, 5'd1));
    send_div(make_div(ones, FULL_BITS'(3), 1'b0, 5'd10));
    r1 = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    send_div(make_div(r1, FULL_BITS'(1) << 64, 1'b1, 5'd2));
    send_div(make_div(r1, FULL_BITS'(1) << 128, 1'b0, 5'd27));
    send_div(make_div((FULL_BITS'(1) << 128) - FULL_BITS'(1),
                      (FULL_BITS'(1) << 64) + FULL_BITS'(1), 1'b1, 5'd9));
    send_div(make_div(ones, ones - FULL_BITS'(1), 1'b0, 5'd30));
    send_div(make_div(ones - FULL_BITS'(1), ones, 1'b1, 5'd14));
    send_div(make_div(r1 & ((FULL_BITS'(1) << 64) - FULL_BITS'(1)),
                      FULL_BITS'($urandom_range(1000, 1)), 1'b1, 5'd20));
    send_div(make_div(r1 & ~((FULL_BITS'(1) << 128) - FULL_BITS'(1)),
                      FULL_BITS'(64'hffff_ffff_ffff_fffb), 1'b0, 5'd6));
    send_div(make_div(r1, '0, 1'b0, 5'd0));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 66; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 66; end
        default: begin idle_pct = 31; stall_pct <= 31; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold off the response side while requests keep coming
        if (phase == 0 && i == 100)
          holdoff_token <= ~holdoff_token;
        // pause until the block is empty, then resume
        if (phase == 0 && i == 110)
          drain();
        send_div(rand_div());
      end
      drain();
    end

    repeat (SETTLE_TIME) @(posedge clk);
    $display("tb: %0d divisions compared, %0d with a zero divisor, %0d with a dividend below",
             checked, zero_divisors, short_dividends);
    $display("tb: idling phases none, sender, receiver and both, plus a %0d-cycle hold-off",
             HOLDOFF_LEN);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
